@@ rtl/rgb_block_average_downscale_3x3_macros.svh @@
// Assertion macros for the 3x3 block average downscaler.
// Expect clk and arst_n in the scope of each use.
`ifndef RGB_BLOCK_AVERAGE_DOWNSCALE_3X3_MACROS_SVH
`define RGB_BLOCK_AVERAGE_DOWNSCALE_3X3_MACROS_SVH

// hold at every edge out of reset
`define RBAD_ASSERT_HOLDS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence in the same cycle
`define RBAD_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence in the next cycle
`define RBAD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/rbad_pkg.sv @@
// Shared types, constants and helpers of the 3x3 block average downscaler.
// Depends on nothing; every other file but the macros header uses it by scoped names.
package rbad_pkg;

	localparam int MAX_OUT_WIDTH  = 1024;
	localparam int MAX_OUT_HEIGHT = 1024;
	localparam int COL_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
	localparam int ROW_W = (MAX_OUT_HEIGHT > 1) ? $clog2(MAX_OUT_HEIGHT) : 1;

	localparam int CH_W      = 8;
	localparam int SUM_W     = 12;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;

	localparam int RST_OUT_WIDTH  = 640;
	localparam int RST_OUT_HEIGHT = 360;

	// floor(x / 9) == (x * 7282) >> 16 for every x below 9 * 255 + 1
	localparam int RECIP_9     = 7282;
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 16;
	localparam int PROD_W      = SUM_W + RECIP_W;

	localparam logic [1:0] PH_FIRST = 2'd0;
	localparam logic [1:0] PH_LAST  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = CFG_IDX_W'(1);

	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [CH_W-1:0]  chan_t;

	typedef struct packed {
		sum_t blue;
		sum_t green;
		sum_t red;
	} bgr_sum_t;

	typedef struct packed {
		bgr_sum_t total;
		logic     last;
	} blk_res_t;

	function automatic logic [COL_W-1:0] width_last(input logic [CFG_W-1:0] v);
		logic [COL_W-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if (int'(v) > MAX_OUT_WIDTH) begin
			r = COL_W'(MAX_OUT_WIDTH - 1);
		end else begin
			r = COL_W'(v - CFG_W'(1));
		end
		return r;
	endfunction

	function automatic logic [ROW_W-1:0] height_last(input logic [CFG_W-1:0] v);
		logic [ROW_W-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if (int'(v) > MAX_OUT_HEIGHT) begin
			r = ROW_W'(MAX_OUT_HEIGHT - 1);
		end else begin
			r = ROW_W'(v - CFG_W'(1));
		end
		return r;
	endfunction

	function automatic chan_t div9(input sum_t x);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(x) * PROD_W'(RECIP_9);
		return prod[RECIP_SHIFT +: CH_W];
	endfunction

endpackage

@@ rtl/rbad_if.sv @@
// Handshake channels of the 3x3 block average downscaler: pixel in,
// result out and configuration write. Depends on rbad_pkg.
interface rbad_pix_if;
	logic                 valid;
	logic                 ready;
	rbad_pkg::chan_t      blue_in;
	rbad_pkg::chan_t      green_in;
	rbad_pkg::chan_t      red_in;
	modport source(output valid, blue_in, green_in, red_in, input ready);
	modport sink(input valid, blue_in, green_in, red_in, output ready);
endinterface

interface rbad_res_if;
	logic                 valid;
	logic                 ready;
	rbad_pkg::chan_t      blue_out;
	rbad_pkg::chan_t      green_out;
	rbad_pkg::chan_t      red_out;
	logic                 frame_last;
	modport source(output valid, blue_out, green_out, red_out, frame_last, input ready);
	modport sink(input valid, blue_out, green_out, red_out, frame_last, output ready);
endinterface

interface rbad_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [rbad_pkg::CFG_IDX_W-1:0]       index;
	logic [rbad_pkg::CFG_W-1:0]           data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/rbad_front.sv @@
// Front end: config registers, block position counters, row accumulator and
// per-column line store; registers one block total. Depends on rbad_pkg, rbad_if.
`include "rgb_block_average_downscale_3x3_macros.svh"

module rbad_front (
	input  logic               clk,
	input  logic               arst_n,
	rbad_pix_if.sink           pix,
	rbad_cfg_if.sink           cfg,
	output logic               s1_valid,
	output rbad_pkg::blk_res_t s1_data,
	input  logic               s1_ready
);

	logic [rbad_pkg::COL_W-1:0] width_last_q;
	logic [rbad_pkg::ROW_W-1:0] height_last_q;
	logic [1:0]                 col_phase_q;
	logic [1:0]                 row_phase_q;
	logic [rbad_pkg::COL_W-1:0] out_col_q;
	logic [rbad_pkg::ROW_W-1:0] out_row_q;
	rbad_pkg::bgr_sum_t         brs_q;
	rbad_pkg::bgr_sum_t         rd_q;
	rbad_pkg::bgr_sum_t         line_mem [rbad_pkg::MAX_OUT_WIDTH];
	logic                       s1_valid_q;
	rbad_pkg::blk_res_t         s1_data_q;

	logic                       accept;
	logic                       cfg_wr;
	logic                       block_end;
	logic                       last_col;
	logic                       last_row;
	logic                       frame_last;
	logic                       emit;
	rbad_pkg::bgr_sum_t         row_sum;
	rbad_pkg::bgr_sum_t         upper;
	rbad_pkg::bgr_sum_t         total;

	assign cfg.ready = 1'b1;
	assign pix.ready = !s1_valid_q || s1_ready;
	assign accept    = pix.valid && pix.ready;
	assign cfg_wr    = cfg.valid && (cfg.index == rbad_pkg::REG_OUT_WIDTH ||
		cfg.index == rbad_pkg::REG_OUT_HEIGHT);

	assign block_end  = col_phase_q == rbad_pkg::PH_LAST;
	assign last_col   = out_col_q >= width_last_q;
	assign last_row   = out_row_q >= height_last_q;
	assign frame_last = last_col && last_row;
	assign emit       = accept && block_end && row_phase_q == rbad_pkg::PH_LAST;

	always_comb begin
		row_sum.blue  = brs_q.blue + rbad_pkg::SUM_W'(pix.blue_in);
		row_sum.green = brs_q.green + rbad_pkg::SUM_W'(pix.green_in);
		row_sum.red   = brs_q.red + rbad_pkg::SUM_W'(pix.red_in);
		upper         = (row_phase_q == rbad_pkg::PH_FIRST) ? '0 : rd_q;
		total.blue    = row_sum.blue + upper.blue;
		total.green   = row_sum.green + upper.green;
		total.red     = row_sum.red + upper.red;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_last_q  <= rbad_pkg::width_last(rbad_pkg::CFG_W'(rbad_pkg::RST_OUT_WIDTH));
			height_last_q <= rbad_pkg::height_last(rbad_pkg::CFG_W'(rbad_pkg::RST_OUT_HEIGHT));
			col_phase_q   <= rbad_pkg::PH_FIRST;
			row_phase_q   <= rbad_pkg::PH_FIRST;
			out_col_q     <= '0;
			out_row_q     <= '0;
			brs_q         <= '0;
		end else if (cfg_wr) begin
			if (cfg.index == rbad_pkg::REG_OUT_WIDTH) begin
				width_last_q <= rbad_pkg::width_last(cfg.data);
			end else begin
				height_last_q <= rbad_pkg::height_last(cfg.data);
			end
			col_phase_q <= rbad_pkg::PH_FIRST;
			row_phase_q <= rbad_pkg::PH_FIRST;
			out_col_q   <= '0;
			out_row_q   <= '0;
			brs_q       <= '0;
		end else if (accept) begin
			if (!block_end) begin
				col_phase_q <= col_phase_q + 2'd1;
				brs_q       <= row_sum;
			end else begin
				col_phase_q <= rbad_pkg::PH_FIRST;
				brs_q       <= '0;
				if (last_col) begin
					out_col_q <= '0;
					if (row_phase_q == rbad_pkg::PH_LAST) begin
						row_phase_q <= rbad_pkg::PH_FIRST;
						out_row_q   <= last_row ? '0 : out_row_q + rbad_pkg::ROW_W'(1);
					end else begin
						row_phase_q <= row_phase_q + 2'd1;
					end
				end else begin
					out_col_q <= out_col_q + rbad_pkg::COL_W'(1);
				end
			end
		end
	end

	// fetch upper rows at first pixel, store at last, bar the block's bottom row
	always_ff @(posedge clk) begin
		if (accept && col_phase_q == rbad_pkg::PH_FIRST) begin
			rd_q <= line_mem[out_col_q];
		end
		if (accept && block_end && row_phase_q != rbad_pkg::PH_LAST) begin
			line_mem[out_col_q] <= total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (pix.ready) begin
			s1_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			s1_data_q.total <= total;
			s1_data_q.last  <= frame_last;
		end
	end

	assign s1_valid = s1_valid_q;
	assign s1_data  = s1_data_q;

	`RBAD_ASSERT_HOLDS(a_phase_range, col_phase_q <= rbad_pkg::PH_LAST && row_phase_q <= rbad_pkg::PH_LAST, "block phase out of range")
	`RBAD_ASSERT_HOLDS(a_col_range, out_col_q <= width_last_q, "output column past line end")
	`RBAD_ASSERT_NEXT(a_emit_loads, emit, s1_valid_q && s1_data_q.last == $past(frame_last), "block result not loaded")
	`RBAD_ASSERT_NEXT(a_s1_hold, s1_valid_q && !s1_ready, s1_valid_q && $stable(s1_data_q), "stalled block result changed")
	`RBAD_ASSERT_NEXT(a_row_clear, accept && block_end, brs_q == '0, "row accumulator not cleared")

endmodule

@@ rtl/rbad_out.sv @@
// Output stage: divides each block total by nine and holds the result item.
// Depends on rbad_pkg, rbad_if.
module rbad_out (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s1_valid,
	input  rbad_pkg::blk_res_t s1_data,
	output logic               s1_ready,
	rbad_res_if.source         res
);

	logic            out_valid_q;
	rbad_pkg::chan_t blue_q;
	rbad_pkg::chan_t green_q;
	rbad_pkg::chan_t red_q;
	logic            last_q;

	assign s1_ready = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_ready) begin
			out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid && s1_ready) begin
			blue_q  <= rbad_pkg::div9(s1_data.total.blue);
			green_q <= rbad_pkg::div9(s1_data.total.green);
			red_q   <= rbad_pkg::div9(s1_data.total.red);
			last_q  <= s1_data.last;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.blue_out   = blue_q;
	assign res.green_out  = green_q;
	assign res.red_out    = red_q;
	assign res.frame_last = last_q;

endmodule

@@ rtl/rgb_block_average_downscale_3x3.sv @@
// 3x3 block average downscaler for 8-bit BGR pixels in raster order. One pixel
// item is taken every clock cycle while the result side keeps up; each block's
// result item goes through a block total register and an output register.
// The line store holds one entry per output column, is read at the first
// pixel of each block row, written at the last pixel of its upper two rows,
// and needs no clearing pass after reset. A write to out_width or out_height
// restarts the frame. Depends on rbad_pkg, rbad_if, rbad_front, rbad_out.
module rgb_block_average_downscale_3x3 (
	input  logic       clk,
	input  logic       arst_n,
	rbad_pix_if.sink   pix,
	rbad_res_if.source res,
	rbad_cfg_if.sink   cfg
);

	logic               s1_valid;
	logic               s1_ready;
	rbad_pkg::blk_res_t s1_data;

	rbad_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix      (pix),
		.cfg      (cfg),
		.s1_valid (s1_valid),
		.s1_data  (s1_data),
		.s1_ready (s1_ready)
	);

	rbad_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (s1_valid),
		.s1_data  (s1_data),
		.s1_ready (s1_ready),
		.res      (res)
	);

endmodule
